>>> design/lset_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lset_pkg: shared types and constants for the line sensor error tracker
// Frame and result formats, register indexes, reset values and pair wiring.
// ---------------------------------------------------------------------------
package lset_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int NUM_SENSORS = 8;
  localparam int NUM_PAIRS   = 3;
  localparam int ERR_W       = 16;

  localparam int THR_W   = 12;
  localparam int OUTER_W = 15;
  localparam int ALPHA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // compare width covers both the sample and the threshold registers
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  localparam logic [THR_W-1:0]   LOW_THR_RST  = THR_W'(1000);
  localparam logic [THR_W-1:0]   HIGH_THR_RST = THR_W'(2000);
  localparam logic [OUTER_W-1:0] OUTER_RST    = OUTER_W'(1280);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(256);

  // Q8.8 unit error
  localparam logic signed [ERR_W:0] Q_ONE = (ERR_W+1)'(256);

  // mask queue between qualifier and smoothing
  localparam int Q_DEPTH = 2;

  // sensor positions of the left and right member of each pair
  localparam int unsigned PAIR_LEFT  [NUM_PAIRS] = '{0, 3, 6};
  localparam int unsigned PAIR_RIGHT [NUM_PAIRS] = '{2, 5, 7};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_OUTER    = 2'd2,
    REG_ALPHA    = 2'd3
  } lset_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_front_left;
    logic [SAMPLE_BITS-1:0] sample_front_mid;
    logic [SAMPLE_BITS-1:0] sample_front_right;
    logic [SAMPLE_BITS-1:0] sample_back_left;
    logic [SAMPLE_BITS-1:0] sample_back_mid;
    logic [SAMPLE_BITS-1:0] sample_back_right;
    logic [SAMPLE_BITS-1:0] sample_side_one;
    logic [SAMPLE_BITS-1:0] sample_side_two;
  } lset_in_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0]   tape_mask;
    logic signed [ERR_W-1:0]  front_error;
    logic signed [ERR_W-1:0]  back_error;
    logic signed [ERR_W-1:0]  side_error;
  } lset_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lset_qstat_t;

endpackage

>>> design/lset_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lset_front: hysteresis qualifier
// Updates the eight stored tape flags from each accepted frame and pushes
// the resulting mask into the queue.
// ---------------------------------------------------------------------------
module lset_front
  import lset_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  lset_in_t               in_item,
  output logic                   in_stall,
  input  logic [THR_W-1:0]       clear_level,
  input  logic [THR_W-1:0]       set_level,
  input  lset_qstat_t            qstat,
  output logic                   push,
  output logic [NUM_SENSORS-1:0] push_mask
);

  logic [NUM_SENSORS-1:0] tape_flags;
  logic [NUM_SENSORS-1:0] tape_flags_next;
  logic [SAMPLE_BITS-1:0] samples [NUM_SENSORS];

  assign samples[0] = in_item.sample_front_left;
  assign samples[1] = in_item.sample_front_mid;
  assign samples[2] = in_item.sample_front_right;
  assign samples[3] = in_item.sample_back_left;
  assign samples[4] = in_item.sample_back_mid;
  assign samples[5] = in_item.sample_back_right;
  assign samples[6] = in_item.sample_side_one;
  assign samples[7] = in_item.sample_side_two;

  always_comb begin
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    lo = CMP_W'(clear_level);
    hi = CMP_W'(set_level);
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s = CMP_W'(samples[i]);
      if (tape_flags[i] && (s < lo)) begin
        tape_flags_next[i] = 1'b0;
      end else if (!tape_flags[i] && (s > hi)) begin
        tape_flags_next[i] = 1'b1;
      end else begin
        tape_flags_next[i] = tape_flags[i];
      end
    end
  end

  assign in_stall  = qstat.full;
  assign push      = in_valid && !in_stall;
  assign push_mask = tape_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tape_flags <= '0;
    end else if (push) begin
      tape_flags <= tape_flags_next;
    end
  end

endmodule

>>> design/lset_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lset_queue: mask queue
// Short FIFO of tape masks between the qualifier and the smoothing stage.
// ---------------------------------------------------------------------------
module lset_queue
  import lset_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [NUM_SENSORS-1:0] push_mask,
  input  logic                   pop,
  output logic [NUM_SENSORS-1:0] pop_mask,
  output lset_qstat_t            qstat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [NUM_SENSORS-1:0] mem [Q_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.full  = (count == CNT_W'(Q_DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_mask    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from empty mask queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("mask queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("mask queue count did not follow push");

endmodule

>>> design/lset_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lset_back: pair error smoothing
// Pops a mask, forms the raw error of each pair, smooths it into the stored
// error and holds the result in the output register.
// ---------------------------------------------------------------------------
module lset_back
  import lset_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lset_qstat_t            qstat,
  input  logic [NUM_SENSORS-1:0] pop_mask,
  output logic                   pop,
  input  logic [OUTER_W-1:0]     lost_error,
  input  logic [ALPHA_W-1:0]     alpha,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lset_out_t              out_item
);

  logic signed [ERR_W-1:0] err      [NUM_PAIRS];
  logic signed [ERR_W-1:0] err_next [NUM_PAIRS];
  logic [ALPHA_W-1:0]      a_eff;

  assign a_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign pop   = !qstat.empty && (!out_valid || !out_stall);

  // new = prev + a*(raw - prev)/256, floored and saturated: one multiply per pair
  always_comb begin
    logic                    l;
    logic                    r;
    logic signed [ERR_W:0]   raw;
    logic signed [ERR_W:0]   diff;
    logic signed [ERR_W+9:0] prod;
    logic signed [ERR_W+10:0] sum;
    logic signed [ERR_W+2:0] shr;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      l = pop_mask[PAIR_LEFT[p]];
      r = pop_mask[PAIR_RIGHT[p]];
      if (l && !r) begin
        raw = Q_ONE;
      end else if (!l && r) begin
        raw = -Q_ONE;
      end else if (!l && !r && (err[p] > 0)) begin
        raw = $signed({2'b00, lost_error});
      end else if (!l && !r && (err[p] < 0)) begin
        raw = -$signed({2'b00, lost_error});
      end else begin
        raw = '0;
      end
      diff = raw - {err[p][ERR_W-1], err[p]};
      prod = $signed({1'b0, a_eff}) * diff;
      sum  = $signed({{3{err[p][ERR_W-1]}}, err[p], 8'b0}) + {prod[ERR_W+9], prod};
      shr  = sum[ERR_W+10:8];
      if (shr > (ERR_W+3)'(32767)) begin
        err_next[p] = 16'sh7fff;
      end else if (shr < -(ERR_W+3)'(32768)) begin
        err_next[p] = 16'sh8000;
      end else begin
        err_next[p] = shr[ERR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        err[p] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
          err[p] <= err_next[p];
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.tape_mask   <= pop_mask;
      out_item.front_error <= err_next[0];
      out_item.back_error  <= err_next[1];
      out_item.side_error  <= err_next[2];
    end
  end

endmodule

>>> design/line_sensor_error_tracker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_sensor_error_tracker_top: line sensor error tracker
// Hysteresis-qualified tape flags and smoothed Q8.8 errors for the front,
// back and side sensor pairs, one result per frame.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | in_item   (lset_in_t, eight samples)
//  out     | out_valid / out_stall| out_item  (lset_out_t, mask + errors)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One frame per cycle sustained while out_stall is low; each frame updates
//  the flags and enters the mask queue on the edge that takes it, and is
//  smoothed into the output register when its mask is popped. The
//  stored-error update is a loop through the err register with one 9x17
//  multiply per pair. Reset is synchronous; flags and errors clear to zero.
//  A two-entry mask queue lets the input side keep taking frames while a
//  result waits; in_stall rises only when that queue is full.
// ---------------------------------------------------------------------------
module line_sensor_error_tracker_top
  import lset_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lset_in_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lset_out_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0]       clear_level;
  logic [THR_W-1:0]       set_level;
  logic [OUTER_W-1:0]     lost_error;
  logic [ALPHA_W-1:0]     alpha;
  logic                   push;
  logic                   pop;
  logic [NUM_SENSORS-1:0] push_mask;
  logic [NUM_SENSORS-1:0] pop_mask;
  lset_qstat_t            qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_level <= LOW_THR_RST;
      set_level   <= HIGH_THR_RST;
      lost_error  <= OUTER_RST;
      alpha       <= ALPHA_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lset_reg_t'(cfg_index))
        REG_LOW_THR:  clear_level <= cfg_data[THR_W-1:0];
        REG_HIGH_THR: set_level   <= cfg_data[THR_W-1:0];
        REG_OUTER:    lost_error  <= cfg_data[OUTER_W-1:0];
        REG_ALPHA:    alpha       <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  lset_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .in_stall    (in_stall),
    .clear_level (clear_level),
    .set_level   (set_level),
    .qstat       (qstat),
    .push        (push),
    .push_mask   (push_mask)
  );

  lset_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_mask (push_mask),
    .pop       (pop),
    .pop_mask  (pop_mask),
    .qstat     (qstat)
  );

  lset_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .pop_mask   (pop_mask),
    .pop        (pop),
    .lost_error (lost_error),
    .alpha      (alpha),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
